/* rtl/lkfr_pkg.sv */
// ----------------------------------------------------------------------------
// lkfr_pkg
// Shared types and constants for the LRU-K frame replacer.
// ----------------------------------------------------------------------------
package lkfr_pkg;

  localparam int unsigned LKFR_FRAME_COUNT = 64;
  localparam int unsigned FRAME_W          = 8;
  localparam int unsigned COUNT_W          = 8;
  localparam int unsigned TOTAL_W          = 9;
  localparam logic [COUNT_W-1:0] K_RESET   = 8'd2;

  typedef enum logic [1:0] {
    FN_ACCESS = 2'd0,
    FN_SET    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_EVICT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_PINNED  = 2'd2,
    ST_NOTHING = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_SEL  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan;
    logic sel;
    logic take;
    logic recency;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_evict;
    logic found;
    logic out_free;
  } sts_t;

endpackage

/* rtl/lkfr_ctrl.sv */
// ----------------------------------------------------------------------------
// lkfr_ctrl
// Sequencer: accepts a request, runs the update or the one- or two-phase
// victim search, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lkfr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkfr_pkg::sts_t sts,
  output lkfr_pkg::cmd_t cmd
);
  import lkfr_pkg::*;

  state_t state, state_next;
  logic   rec, rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rec   <= 1'b0;
    end else begin
      state <= state_next;
      rec   <= rec_next;
    end
  end

  always_comb begin
    state_next  = state;
    rec_next    = rec;
    cmd         = '0;
    cmd.recency = rec;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_evict) begin
          rec_next   = 1'b0;
          state_next = S_SCAN;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_RES;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        if (sts.found || rec) begin
          state_next = S_RES;
        end else begin
          rec_next   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.take   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_scan_then_sel: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |=> cmd.sel) else $error("scan not followed by select");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !in_stall) else $error("not idle after result");
  a_second_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd.sel && !sts.found && !rec) |=> (cmd.scan && rec))
    else $error("recency phase missing");

endmodule

/* rtl/lkfr_dp.sv */
// ----------------------------------------------------------------------------
// lkfr_dp
// Frame state, order matrix, victim search and output register.
// ----------------------------------------------------------------------------
module lkfr_dp #(
  parameter int unsigned FRAME_COUNT = lkfr_pkg::LKFR_FRAME_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lkfr_pkg::COUNT_W-1:0]     cfg_data,
  input  logic [1:0]                       func,
  input  logic [lkfr_pkg::FRAME_W-1:0]     frame,
  input  logic                             evictable_flag,
  input  lkfr_pkg::cmd_t                   cmd,
  output lkfr_pkg::sts_t                   sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [lkfr_pkg::FRAME_W-1:0]     victim_frame,
  output logic [lkfr_pkg::TOTAL_W-1:0]     evictable_count
);
  import lkfr_pkg::*;

  localparam int unsigned IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  logic [FRAME_COUNT-1:0]                 tracked;
  logic [FRAME_COUNT-1:0]                 evm;
  logic [COUNT_W-1:0]                     cnt [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]                 mat [FRAME_COUNT];  // row i bit j: i newer than j
  logic [TOTAL_W-1:0]                     total;
  logic [COUNT_W-1:0]                     k_thr;
  func_t                                  func_q;
  logic [FRAME_W-1:0]                     frame_q;
  logic                                   flag_q;
  logic [FRAME_COUNT-1:0]                 older_q;
  status_t                                res_status;
  logic [IW-1:0]                          res_victim;

  logic [IW-1:0]          idx;
  logic                   oor;
  logic [COUNT_W-1:0]     cnt_inc;
  logic [FRAME_COUNT-1:0] cand;
  logic [FRAME_COUNT-1:0] older_d;
  logic [FRAME_COUNT-1:0] sel;
  logic [IW-1:0]          vic_idx;
  logic                   found;
  logic                   mtf_en;
  status_t                st_exec;
  logic                   trk_wr, trk_val, evm_wr, evm_val, cnt_wr, tot_up, tot_dn;
  logic [COUNT_W-1:0]     cnt_val;

  assign idx     = frame_q[IW-1:0];
  assign oor     = 9'(frame_q) >= 9'(FRAME_COUNT);
  assign cnt_inc = (cnt[idx] != '1) ? cnt[idx] + 1'b1 : cnt[idx];

  always_comb begin
    for (int f = 0; f < FRAME_COUNT; f++) begin
      cand[f]    = tracked[f] & evm[f] & ((cnt[f] >= k_thr) == cmd.recency);
      older_d[f] = |(mat[f] & cand);
    end
  end

  assign sel   = cand & ~older_q;
  assign found = |sel;

  always_comb begin
    vic_idx = '0;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      if (sel[f]) vic_idx = vic_idx | IW'(f);
    end
  end

  always_comb begin
    mtf_en  = 1'b0;
    st_exec = ST_OK;
    trk_wr  = 1'b0;
    trk_val = 1'b0;
    evm_wr  = 1'b0;
    evm_val = 1'b0;
    cnt_wr  = 1'b0;
    cnt_val = cnt_inc;
    tot_up  = 1'b0;
    tot_dn  = 1'b0;
    if (cmd.exec) begin
      if (oor) begin
        st_exec = ST_RANGE;
      end else begin
        case (func_q)
          FN_ACCESS: begin
            cnt_wr = 1'b1;
            if (!tracked[idx]) begin
              trk_wr  = 1'b1;
              trk_val = 1'b1;
              evm_wr  = 1'b1;
              cnt_val = COUNT_W'(1);
              mtf_en  = 1'b1;
            end else begin
              mtf_en = cnt_inc >= k_thr;
            end
          end
          FN_SET: begin
            if (tracked[idx] && (flag_q != evm[idx])) begin
              evm_wr  = 1'b1;
              evm_val = flag_q;
              tot_up  = flag_q;
              tot_dn  = !flag_q;
            end
          end
          FN_REMOVE: begin
            if (tracked[idx]) begin
              if (!evm[idx]) begin
                st_exec = ST_PINNED;
              end else begin
                trk_wr = 1'b1;
                tot_dn = 1'b1;
              end
            end
          end
          FN_EVICT: ;
          default: ;
        endcase
      end
    end
    if (cmd.sel && found) begin
      trk_wr = 1'b1;
      tot_dn = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked   <= '0;
      total     <= '0;
      k_thr     <= K_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) k_thr <= cfg_data;
      if (trk_wr) tracked[cmd.sel ? vic_idx : idx] <= trk_val;
      if (tot_up) total <= total + 1'b1;
      else if (tot_dn) total <= total - 1'b1;
      if (cmd.take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q  <= func_t'(func);
      frame_q <= frame;
      flag_q  <= evictable_flag;
    end
    if (evm_wr) evm[idx] <= evm_val;
    if (cnt_wr) cnt[idx] <= cnt_val;
    if (mtf_en) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        for (int j = 0; j < FRAME_COUNT; j++) begin
          if (i == 32'(idx)) mat[i][j] <= (j != 32'(idx));
          else if (j == 32'(idx)) mat[i][j] <= 1'b0;
        end
      end
    end
    if (cmd.scan) older_q <= older_d;
    if (cmd.exec) begin
      res_status <= st_exec;
      res_victim <= '0;
    end
    if (cmd.sel) begin
      res_status <= found ? ST_OK : ST_NOTHING;
      res_victim <= found ? vic_idx : '0;
    end
    if (cmd.take) begin
      status          <= res_status;
      victim_frame    <= FRAME_W'(res_victim);
      evictable_count <= total;
    end
  end

  assign sts.is_evict = func_q == FN_EVICT;
  assign sts.found    = found;
  assign sts.out_free = !out_valid || !out_stall;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(FRAME_COUNT)) else $error("evictable total too large");
  a_one_victim: assert property (@(posedge clk) disable iff (rst)
    cmd.sel |-> $onehot0(sel)) else $error("victim not unique");
  a_victim_gone: assert property (@(posedge clk) disable iff (rst)
    (cmd.sel && found) |=> !$past(|(tracked & sel)) || ($countones(tracked) ==
    $countones($past(tracked)) - 1)) else $error("victim still tracked");

endmodule

/* rtl/lru_k_frame_replacer.sv */
// ----------------------------------------------------------------------------
// lru_k_frame_replacer
// LRU-K buffer frame replacement policy with a pairwise order matrix.
// ----------------------------------------------------------------------------
// channel | signals                                        | dir
// cfg     | cfg_we, cfg_data                               | in
// in      | in_valid, in_stall, func, frame, evictable_flag | in (stall out)
// out     | out_valid, out_stall, status, victim_frame,    | out (stall in)
//         |   evictable_count                              |
// Access, set evictable and remove go through the execute and result
// states to the output register; evict runs one matrix scan and one
// select per order, the recency order only when the history order has
// no evictable frame. One request is in flight at a time; the next is
// taken once the result is in the output register. Reset clears tracked
// marks and the count; no clearing pass. A stalled output holds its result.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer #(
  parameter int unsigned FRAME_COUNT = lkfr_pkg::LKFR_FRAME_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lkfr_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [lkfr_pkg::FRAME_W-1:0] frame,
  input  logic                         evictable_flag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [lkfr_pkg::FRAME_W-1:0] victim_frame,
  output logic [lkfr_pkg::TOTAL_W-1:0] evictable_count
);
  import lkfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkfr_dp #(.FRAME_COUNT(FRAME_COUNT)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .func            (func),
    .frame           (frame),
    .evictable_flag  (evictable_flag),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .victim_frame    (victim_frame),
    .evictable_count (evictable_count)
  );

endmodule
